// File: design/kfd_pkg.sv
package kfd_pkg;

    localparam int ByteW  = 8;
    localparam int LenW   = 13;
    localparam int CntW   = 16;

    // KISS special bytes
    localparam logic [ByteW-1:0] FEND  = 8'hC0;
    localparam logic [ByteW-1:0] FESC  = 8'hDB;
    localparam logic [ByteW-1:0] TFEND = 8'hDC;
    localparam logic [ByteW-1:0] TFESC = 8'hDD;

    localparam logic [LenW-1:0] MaxLenReset = 13'd256;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_FRAME = 2'd1,
        ST_ESC   = 2'd2,
        ST_SKIP  = 2'd3
    } t_rx_state;

    typedef enum logic [1:0] {
        EV_DATA  = 2'd0,
        EV_DONE  = 2'd1,
        EV_ABORT = 2'd2
    } t_event;

    typedef struct packed {
        logic [ByteW-1:0] rx_byte;
        logic             buffer_ready;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       event_res;
        logic [ByteW-1:0] data_byte;
        logic [LenW-1:0]  payload_len;
        logic [CntW-1:0]  error_count;
        logic [CntW-1:0]  frame_count;
    } t_out_word;

endpackage

// File: design/kfd_if.sv
interface kfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       buffer_ready;

    modport source (output valid, output rx_byte, output buffer_ready, input ready);
    modport sink   (input valid, input rx_byte, input buffer_ready, output ready);
endinterface

interface kfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [7:0]  data_byte;
    logic [12:0] payload_len;
    logic [15:0] error_count;
    logic [15:0] frame_count;

    modport source (output valid, output event_res, output data_byte, output payload_len,
                    output error_count, output frame_count, input ready);
    modport sink   (input valid, input event_res, input data_byte, input payload_len,
                    input error_count, input frame_count, output ready);
endinterface

interface kfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] max_frame_length;

    modport source (output valid, output max_frame_length, input ready);
    modport sink   (input valid, input max_frame_length, output ready);
endinterface

// File: design/kfd_in_stage.sv
module kfd_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    kfd_in_if.sink            i_in,
    input  logic              i_take,
    output logic              o_valid,
    output kfd_pkg::t_in_word o_word
);
    import kfd_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    assign i_in.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_word     = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_word.rx_byte      <= i_in.rx_byte;
            r_word.buffer_ready <= i_in.buffer_ready;
        end
    end

endmodule

// File: design/kfd_decoder.sv
module kfd_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    kfd_cfg_if.sink            i_cfg,
    input  logic               i_valid,
    input  kfd_pkg::t_in_word  i_word,
    input  logic               i_out_free,
    output logic               o_take,
    output logic               o_res_valid,
    output kfd_pkg::t_out_word o_res
);
    import kfd_pkg::*;

    t_rx_state       r_state, n_state, w_state;
    logic [LenW-1:0] r_max;
    logic [LenW-1:0] r_byte_count, n_byte_count, w_byte_count;
    logic            r_skip_first, n_skip_first;
    logic [CntW-1:0] r_errors, n_errors;
    logic [CntW-1:0] r_frames, n_frames;
    logic            w_abort;
    logic [LenW-1:0] w_len_inc;
    logic [ByteW-1:0] b;

    assign b       = i_word.rx_byte;
    assign o_take  = i_valid && i_out_free;
    assign i_cfg.ready = 1'b1;

    // capacity check comes before decode, only while a frame is open
    assign w_abort      = ((r_state == ST_FRAME) || (r_state == ST_ESC)) &&
                          (r_byte_count >= r_max);
    assign w_state      = w_abort ? ST_IDLE : r_state;
    assign w_byte_count = w_abort ? '0 : r_byte_count;
    assign w_len_inc    = w_byte_count + 1'b1;

    // next state
    always_comb begin
        n_state      = w_state;
        n_byte_count = w_byte_count;
        n_skip_first = r_skip_first;
        n_errors     = r_errors + {{(CntW-1){1'b0}}, w_abort};
        n_frames     = r_frames;
        case (w_state)
            ST_IDLE: begin
                if (b == FEND) begin
                    if (!i_word.buffer_ready) begin
                        n_state = ST_SKIP;
                    end else begin
                        n_byte_count = '0;
                        n_skip_first = 1'b1;
                        n_state      = ST_FRAME;
                    end
                end
            end
            ST_FRAME: begin
                if (b == FESC) begin
                    n_state = ST_ESC;
                end else if (b == FEND) begin
                    if (w_byte_count != '0) begin
                        n_frames = r_frames + 1'b1;
                        n_state  = ST_IDLE;
                    end
                end else if (r_skip_first) begin
                    n_skip_first = 1'b0;
                end else begin
                    n_byte_count = w_len_inc;
                end
            end
            ST_ESC: begin
                n_state = ST_FRAME;
                if ((b == TFESC) || (b == TFEND)) begin
                    n_byte_count = w_len_inc;
                end
            end
            ST_SKIP: begin
                if (b == FEND) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // result word
    always_comb begin
        o_res_valid       = w_abort;
        o_res.event_res   = EV_ABORT;
        o_res.data_byte   = '0;
        o_res.payload_len = r_byte_count;
        o_res.error_count = n_errors;
        o_res.frame_count = n_frames;
        case (w_state)
            ST_FRAME: begin
                if (b == FEND) begin
                    if (w_byte_count != '0) begin
                        o_res_valid       = 1'b1;
                        o_res.event_res   = EV_DONE;
                        o_res.payload_len = w_byte_count;
                    end
                end else if ((b != FESC) && !r_skip_first) begin
                    o_res_valid       = 1'b1;
                    o_res.event_res   = EV_DATA;
                    o_res.data_byte   = b;
                    o_res.payload_len = w_len_inc;
                end
            end
            ST_ESC: begin
                if ((b == TFESC) || (b == TFEND)) begin
                    o_res_valid       = 1'b1;
                    o_res.event_res   = EV_DATA;
                    o_res.data_byte   = (b == TFESC) ? FESC : FEND;
                    o_res.payload_len = w_len_inc;
                end
            end
            default: begin
            end
        endcase
        o_res_valid = o_res_valid && o_take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_byte_count <= '0;
            r_skip_first <= 1'b0;
            r_errors     <= '0;
            r_frames     <= '0;
        end else if (o_take) begin
            r_state      <= n_state;
            r_byte_count <= n_byte_count;
            r_skip_first <= n_skip_first;
            r_errors     <= n_errors;
            r_frames     <= n_frames;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MaxLenReset;
        end else if (i_cfg.valid) begin
            r_max <= i_cfg.max_frame_length;
        end
    end

    a_abort_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && w_abort) |=> (r_errors == $past(r_errors) + 1'b1))
        else $error("overflow abort did not bump error count");

    a_done_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.event_res == EV_DONE)) |=>
        (r_frames == $past(r_frames) + 1'b1) && (r_state == ST_IDLE))
        else $error("frame completion did not count or close frame");

    a_esc_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && (r_state == ST_ESC)) |=>
        ((r_state == ST_FRAME) || (r_state == ST_IDLE) || (r_state == ST_SKIP)))
        else $error("escape state held past one byte");

endmodule

// File: design/kfd_out_reg.sv
module kfd_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  kfd_pkg::t_out_word i_res,
    output logic               o_free,
    kfd_out_if.source          o_out
);
    import kfd_pkg::*;

    logic      r_valid;
    t_out_word r_res;

    assign o_free            = !r_valid || o_out.ready;
    assign o_out.valid       = r_valid;
    assign o_out.event_res   = r_res.event_res;
    assign o_out.data_byte   = r_res.data_byte;
    assign o_out.payload_len = r_res.payload_len;
    assign o_out.error_count = r_res.error_count;
    assign o_out.frame_count = r_res.frame_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_res <= i_res;
        end
    end

endmodule

// File: design/kiss_frame_deframer.sv
// Channel   Dir  Payload                                            Handshake
// i_in      in   rx_byte[7:0], buffer_ready                         valid/ready
// o_out     out  event_res[1:0], data_byte[7:0], payload_len[12:0],
//                error_count[15:0], frame_count[15:0]               valid/ready
// i_cfg     in   max_frame_length[12:0]                             valid/ready (ready tied 1)
//
// One word per cycle while the result register is free or draining. A word accepted
// into the input register is decoded from there into the result register.
// Reset (i_rst_n low, sync) clears control state, counters, and sets capacity to 256.
// A stalled output holds its word; input keeps flowing as long as the result
// register is free or is being drained in the same cycle.
module kiss_frame_deframer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kfd_in_if.sink    i_in,
    kfd_cfg_if.sink   i_cfg,
    kfd_out_if.source o_out
);
    import kfd_pkg::*;

    logic      w_in_valid;
    t_in_word  w_in_word;
    logic      w_take;
    logic      w_out_free;
    logic      w_res_valid;
    t_out_word w_res;

    // input register; drains whenever the decoder takes a word
    kfd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_valid (w_in_valid),
        .o_word  (w_in_word)
    );

    // KISS state machine, capacity register, counters
    kfd_decoder u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_valid     (w_in_valid),
        .i_word      (w_in_word),
        .i_out_free  (w_out_free),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // result register; words that decode to nothing are simply consumed
    kfd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_out   (o_out)
    );

endmodule

// File: tb/sv/kiss_frame_deframer_test.sv
module kiss_frame_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kfd_pkg::*;

    // ---------------------------------------------------------------
    // Run plan
    // ---------------------------------------------------------------
    localparam int ResetCycles   = 8;
    localparam int DrainCycles   = 6;     // input and result registers plus margin
    localparam int StallLimit    = 5000;  // cycles with no handshake at all
    localparam int ItemsPerPhase = 145;
    localparam int NumPhases     = 9;
    localparam int DirRows       = 25;
    localparam int Cap1Row       = 16;    // directed rows from here run at capacity 1

    // How a stimulus row is checked: by the predictor, or against a
    // hand-written expectation (no word, or one given word).
    typedef enum logic [1:0] {
        CHK_MODEL = 2'd0,
        CHK_NONE  = 2'd1,
        CHK_WORD  = 2'd2
    } t_check_kind;

    typedef struct packed {
        logic [ByteW-1:0] rx_byte;
        logic             buf_rdy;
        t_check_kind      kind;
        t_out_word        result;
    } t_stim_row;

    localparam t_out_word NoWord = '0;

    // ---------------------------------------------------------------
    // Clock, reset, channels, DUT
    // ---------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always #10 i_clk = ~i_clk;

    kfd_in_if  in_if ();
    kfd_cfg_if cfg_if ();
    kfd_out_if out_if ();

    kiss_frame_deframer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // ---------------------------------------------------------------
    // Predictor state: mirrors the deframer after reset
    // ---------------------------------------------------------------
    t_rx_state        rx_st      = ST_IDLE;
    logic [LenW-1:0]  stored_len = '0;
    logic             drop_type  = 1'b0;   // TNC type byte still to be dropped
    logic [CntW-1:0]  err_cnt    = '0;
    logic [CntW-1:0]  frm_cnt    = '0;
    logic [LenW-1:0]  cap_len    = MaxLenReset;

    t_out_word   due_words [$];    // decoded words the DUT still owes us
    t_stim_row   row_checks [$];   // one entry per word sent, in send order

    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned words_sent   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned fail_count   = 0;

    // Directed rows. Typed expectations only where plain to read off the
    // KISS rules; most mid-frame data goes through the predictor.
    // Counters start at zero after reset.
    t_stim_row dir_rows [DirRows] = '{
        // idle: plain byte ignored, then open
        '{8'h00, 1'b1, CHK_NONE, NoWord},
        '{8'hC0, 1'b1, CHK_NONE, NoWord},
        // empty frame: delimiter ignored, frame stays open
        '{8'hC0, 1'b1, CHK_NONE, NoWord},
        // escape while type byte still pending: stored anyway
        '{8'hDB, 1'b1, CHK_NONE, NoWord},
        '{8'hDC, 1'b0, CHK_WORD, '{EV_DATA, 8'hC0, 13'd1, 16'd0, 16'd0}},
        // now the type byte goes
        '{8'h00, 1'b1, CHK_NONE, NoWord},
        '{8'hFF, 1'b1, CHK_MODEL, NoWord},
        '{8'hDB, 1'b0, CHK_NONE, NoWord},
        '{8'hDD, 1'b1, CHK_MODEL, NoWord},
        // bad escape: dropped
        '{8'hDB, 1'b1, CHK_NONE, NoWord},
        '{8'h41, 1'b1, CHK_NONE, NoWord},
        '{8'hC0, 1'b1, CHK_WORD, '{EV_DONE, 8'h00, 13'd3, 16'd0, 16'd1}},
        // no buffer: skip to next delimiter, which only returns to idle
        '{8'hC0, 1'b0, CHK_NONE, NoWord},
        '{8'hDB, 1'b1, CHK_NONE, NoWord},
        '{8'hC0, 1'b1, CHK_NONE, NoWord},
        '{8'h12, 1'b1, CHK_NONE, NoWord},
        // capacity 1 from here
        '{8'hC0, 1'b1, CHK_NONE, NoWord},
        '{8'h5A, 1'b1, CHK_NONE, NoWord},
        '{8'h00, 1'b1, CHK_MODEL, NoWord},
        // full frame aborted by its closer; the closer then reopens
        '{8'hC0, 1'b1, CHK_WORD, '{EV_ABORT, 8'h00, 13'd1, 16'd1, 16'd1}},
        '{8'hA5, 1'b0, CHK_NONE, NoWord},
        '{8'hDB, 1'b1, CHK_NONE, NoWord},
        '{8'hDC, 1'b1, CHK_MODEL, NoWord},
        // abort on an escape byte, decoded as idle afterwards
        '{8'hDB, 1'b1, CHK_WORD, '{EV_ABORT, 8'h00, 13'd1, 16'd2, 16'd1}},
        '{8'hC0, 1'b0, CHK_NONE, NoWord}
    };

    // Capacity per random phase: zero, small, and the wide extremes.
    logic [LenW-1:0] cap_plan [NumPhases] = '{
        13'd0, 13'd1, 13'd2, 13'd5, 13'd4096, 13'd8191, 13'd3, 13'd13, 13'd256
    };

    // ---------------------------------------------------------------
    // Predictor: one raw byte in, at most one decoded word out
    // ---------------------------------------------------------------
    task automatic decode_rx_byte(input logic [ByteW-1:0] b, input logic rdy,
                                  output bit emitted, output t_out_word w);
        bit              aborted;
        logic [LenW-1:0] abort_len;
        aborted   = 1'b0;
        abort_len = '0;
        emitted   = 1'b0;
        w         = NoWord;

        // capacity test comes first, only with a frame open
        if ((rx_st == ST_FRAME || rx_st == ST_ESC) && stored_len >= cap_len) begin
            err_cnt    = err_cnt + 1'b1;
            abort_len  = stored_len;
            stored_len = '0;
            rx_st      = ST_IDLE;
            aborted    = 1'b1;
        end

        case (rx_st)
            ST_IDLE: begin
                if (b == FEND) begin
                    if (!rdy) begin
                        rx_st = ST_SKIP;
                    end else begin
                        stored_len = '0;
                        drop_type  = 1'b1;
                        rx_st      = ST_FRAME;
                    end
                end
            end
            ST_FRAME: begin
                if (b == FESC) begin
                    rx_st = ST_ESC;
                end else if (b == FEND) begin
                    if (stored_len != 0) begin
                        frm_cnt = frm_cnt + 1'b1;
                        rx_st   = ST_IDLE;
                        w       = '{EV_DONE, 8'h00, stored_len, err_cnt, frm_cnt};
                        emitted = 1'b1;
                    end
                end else if (drop_type) begin
                    drop_type = 1'b0;
                end else begin
                    stored_len = stored_len + 1'b1;
                    w          = '{EV_DATA, b, stored_len, err_cnt, frm_cnt};
                    emitted    = 1'b1;
                end
            end
            ST_ESC: begin
                rx_st = ST_FRAME;
                if (b == TFESC || b == TFEND) begin
                    stored_len = stored_len + 1'b1;
                    w = '{EV_DATA, (b == TFESC) ? FESC : FEND, stored_len, err_cnt, frm_cnt};
                    emitted = 1'b1;
                end
            end
            default: begin
                if (b == FEND) begin
                    rx_st = ST_IDLE;
                end
            end
        endcase

        if (!emitted && aborted) begin
            w       = '{EV_ABORT, 8'h00, abort_len, err_cnt, frm_cnt};
            emitted = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned seen);
        if (want != seen) begin
            $error("%s: expected %0d, actual %0d", name, want, seen);
            fail_count++;
        end
    endtask

    // ---------------------------------------------------------------
    // Scoreboard: all handshakes sampled at the rising edge, where the
    // values seen are the ones from before the edge.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        bit        emitted;
        bit        moved;
        t_out_word predicted;
        t_out_word want;
        t_stim_row row;
        moved = 1'b0;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                cap_len = cfg_if.max_frame_length;
                moved   = 1'b1;
            end
            if (in_if.valid && in_if.ready) begin
                moved = 1'b1;
                row   = row_checks.pop_front();
                // predictor always runs so its state tracks the DUT
                decode_rx_byte(in_if.rx_byte, in_if.buffer_ready, emitted, predicted);
                case (row.kind)
                    CHK_MODEL: if (emitted) due_words.push_back(predicted);
                    CHK_WORD:  due_words.push_back(row.result);
                    default:   ;
                endcase
            end
            if (out_if.valid && out_if.ready) begin
                moved = 1'b1;
                if (due_words.size() == 0) begin
                    $error("result word with nothing expected: event_res %0d data_byte %0d",
                           out_if.event_res, out_if.data_byte);
                    fail_count++;
                end else begin
                    want = due_words.pop_front();
                    check_field("event_res",   32'(want.event_res),   32'(out_if.event_res));
                    check_field("data_byte",   32'(want.data_byte),   32'(out_if.data_byte));
                    check_field("payload_len", 32'(want.payload_len), 32'(out_if.payload_len));
                    check_field("error_count", 32'(want.error_count), 32'(out_if.error_count));
                    check_field("frame_count", 32'(want.frame_count), 32'(out_if.frame_count));
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // Receiver: random backpressure per cycle
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    // Offer one word, with random gaps first; returns at the accepting edge.
    task automatic send_word(input t_stim_row row);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        row_checks.push_back(row);
        in_if.valid        <= 1'b1;
        in_if.rx_byte      <= row.rx_byte;
        in_if.buffer_ready <= row.buf_rdy;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_byte(input logic [ByteW-1:0] b, input logic rdy);
        send_word('{b, rdy, CHK_MODEL, NoWord});
    endtask

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [ByteW-1:0] rand_byte();
        return ByteW'($urandom_range(0, 255));
    endfunction

    // One frame with random content (bad escapes included), sometimes preceded by noise
    // or left without its closer.
    task automatic send_random_frame(input logic [LenW-1:0] cap);
        int unsigned     n;
        int unsigned     limit;
        int unsigned     sel;
        logic [ByteW-1:0] b;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 4)) send_byte(rand_byte(), rand_bit());
        end
        // opening delimiter, mostly with a buffer ready
        send_byte(FEND, $urandom_range(0, 9) != 0);
        // TNC type byte: anything, delimiters and escapes included
        send_byte(rand_byte(), rand_bit());
        // keep frames short, but around the capacity when it is small
        limit = (cap > 22) ? 24 : cap + 2;
        n     = $urandom_range(0, limit);
        repeat (n) begin
            sel = $urandom_range(0, 15);
            if (sel == 0) begin
                send_byte(FESC, rand_bit());
                send_byte(TFEND, rand_bit());
            end else if (sel == 1) begin
                send_byte(FESC, rand_bit());
                send_byte(TFESC, rand_bit());
            end else if (sel == 2) begin
                send_byte(FESC, rand_bit());
                send_byte(rand_byte(), rand_bit());
            end else begin
                b = rand_byte();
                if (b == FEND || b == FESC) b = b ^ 8'h01;
                send_byte(b, rand_bit());
            end
        end
        sel = $urandom_range(0, 9);
        if (sel != 0) send_byte(FEND, rand_bit());
        if (sel == 1) send_byte(FEND, rand_bit());
    endtask

    // Let every owed word come out, then give the pipe time to empty of
    // words that produce nothing. A clock edge is awaited first so the last
    // accepted word is already in the owed list.
    task automatic settle_block();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [LenW-1:0] value);
        cfg_if.valid            <= 1'b1;
        cfg_if.max_frame_length <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : stimulus
        i_rst_n                 = 1'b0;
        in_if.valid             = 1'b0;
        in_if.rx_byte           = '0;
        in_if.buffer_ready      = 1'b0;
        cfg_if.valid            = 1'b0;
        cfg_if.max_frame_length = '0;
        out_if.ready            = 1'b0;

        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part runs at the reset capacity, then at capacity 1
        src_idle_pct = 19;
        snk_idle_pct = 57;
        for (int i = 0; i < DirRows; i++) begin
            if (i == Cap1Row) begin
                settle_block();
                write_capacity(13'd1);
            end
            send_word(dir_rows[i]);
        end

        // random part: three idle profiles, three capacities each
        for (int p = 0; p < NumPhases; p++) begin
            settle_block();
            case (p / 3)
                0: begin src_idle_pct = 19; snk_idle_pct = 57; end
                1: begin src_idle_pct = 57; snk_idle_pct = 19; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            write_capacity(cap_plan[p]);
            words_sent = 0;
            while (words_sent < ItemsPerPhase) send_random_frame(cap_plan[p]);
        end

        settle_block();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: too long without any handshake means a hang
    initial begin : watchdog
        while (idle_cycles < StallLimit) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

endmodule
